// File: rtl/lfo_pkg.sv
// lfo_pkg: shared types, codes and constants for the lfo phase accumulator
`timescale 1ns / 1ps

package lfo_pkg;

  // command codes of an input item
  typedef enum logic {
    CMD_ADVANCE = 1'b0,
    CMD_SYNC    = 1'b1
  } lfo_cmd_t;

  // waveform select codes
  typedef enum logic [2:0] {
    WAVE_SINE     = 3'd0,
    WAVE_TRIANGLE = 3'd1,
    WAVE_SAW_UP   = 3'd2,
    WAVE_SAW_DOWN = 3'd3,
    WAVE_SQUARE   = 3'd4,
    WAVE_SAMPLE   = 3'd5
  } lfo_wave_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PHASE_INC = 2'd0,
    REG_WAVEFORM  = 2'd1,
    REG_PHASE_OFS = 2'd2,
    REG_DEPTH     = 2'd3
  } lfo_reg_t;

  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [15:0] DEPTH_RESET = 16'h8000;
  localparam logic [31:0] LFSR_MASK   = 32'h8020_0003;
  localparam logic [31:0] LFSR_SEED   = 32'h0000_0001;

  // quarter-wave polynomial coefficients, Q16
  localparam logic [63:0] SIN_A = 64'd102944;
  localparam logic [63:0] SIN_B = 64'd42048;
  localparam logic [63:0] SIN_C = 64'd4640;

  // sin(pi/2 * x) in Q1.15 for x in Q16 (0..65536); used on constants only
  function automatic logic [14:0] quarter_sine_f(input logic [16:0] x);
    logic [63:0] xw;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] y;
    xw = {47'd0, x};
    x2 = (xw * xw) >> 16;
    t  = (SIN_C * x2) >> 16;
    t  = SIN_B - t;
    t  = (t * x2) >> 16;
    t  = SIN_A - t;
    y  = (t * xw) >> 16;
    y  = y >> 1;
    if (y > 64'd32767) begin
      y = 64'd32767;
    end
    return y[14:0];
  endfunction

endpackage

// File: rtl/lfo_phase_accumulator.sv
// lfo_phase_accumulator: 32-bit phase accumulator lfo with four-stage value pipeline
//
// Usage:
//   cfg_*  : register writes (index 0 phase increment, 1 waveform, 2 phase offset,
//            3 depth); always ready, write only while the block is idle.
//   in_*   : one item per transfer. cmd advance moves the phase by
//            increment * samples and yields one result; cmd sync clears the
//            phase and yields nothing.
//   out_*  : bipolar (signed Q1.15, saturated) and unipolar results.
// Throughput: one item per cycle while in_ready is high. The phase, hold value and noise lfsr update
// in the accept cycle (one 32x8 multiply and add), so items follow back to back.
// Pipeline: the offset phase register loads at the transfer edge, then the
// waveform, depth product and output registers follow in that order.
// Reset: phase and hold value clear, lfsr loads one, depth loads full scale,
// the pipeline empties.
// Stall: each stage holds while its successor is full and stalled; bubbles close up, and
// in_ready drops only once all four stages hold results.
`timescale 1ns / 1ps

module lfo_phase_accumulator #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [lfo_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cmd,
  input  logic [7:0]                     in_samples,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [15:0]             out_bipolar,
  output logic [14:0]                    out_unipolar
);

  import lfo_pkg::*;

  localparam int unsigned TB       = SINE_TABLE_BITS;
  localparam int unsigned QSIZE    = 1 << (TB - 2);
  localparam int unsigned X_SHIFT  = 18 - TB;

  // configuration registers
  logic [31:0] phase_inc_r;
  logic [2:0]  waveform_r;
  logic [31:0] phase_ofs_r;
  logic [15:0] depth_r;

  // oscillator state
  logic [31:0]        phase_r;
  logic signed [15:0] held_r;
  logic [31:0]        lfsr_r;
  logic [31:0]        phase_nxt;
  logic signed [15:0] held_nxt;
  logic [31:0]        lfsr_nxt;

  // pipeline valids and payloads
  logic               s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic [31:0]        s1_p_r;
  logic [2:0]         s1_wave_r;
  logic signed [15:0] s1_held_r;
  logic signed [15:0] s2_v_r;
  logic signed [32:0] s3_prod_r;
  logic signed [15:0] out_bipolar_r;
  logic [14:0]        out_unipolar_r;

  logic s1_ready, s2_ready, s3_ready, out_stage_ready;
  logic in_fire, adv_fire;

  // sine quarter-wave table, built at elaboration
  logic [14:0] sine_q [QSIZE+1];
  for (genvar g = 0; g <= QSIZE; g++) begin : g_sine_rom
    localparam logic [16:0] X_VAL = 17'(g << X_SHIFT);
    assign sine_q[g] = quarter_sine_f(X_VAL);
  end

  // handshake and stage flow
  assign out_stage_ready = !out_valid_r || out_ready;
  assign s3_ready        = !s3_valid_r || out_stage_ready;
  assign s2_ready        = !s2_valid_r || s3_ready;
  assign s1_ready        = !s1_valid_r || s2_ready;
  assign in_ready        = s1_ready;
  assign cfg_ready       = 1'b1;
  assign in_fire         = in_valid && in_ready;
  assign adv_fire        = in_fire && (in_cmd == CMD_ADVANCE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= '0;
      waveform_r  <= WAVE_SINE;
      phase_ofs_r <= '0;
      depth_r     <= DEPTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (lfo_reg_t'(cfg_index))
        REG_PHASE_INC: phase_inc_r <= cfg_data;
        REG_WAVEFORM:  waveform_r  <= cfg_data[2:0];
        REG_PHASE_OFS: phase_ofs_r <= cfg_data;
        REG_DEPTH:     depth_r     <= cfg_data[15:0];
        default:       ;
      endcase
    end
  end

  // phase advance, wrap detect and noise refresh
  logic [31:0] advance_lo;
  logic [32:0] phase_sum;
  logic [31:0] lfsr_step;
  always_comb begin
    advance_lo   = phase_inc_r * {24'd0, in_samples};
    phase_sum    = {1'b0, phase_r} + {1'b0, advance_lo};
    lfsr_step    = {1'b0, lfsr_r[31:1]} ^ (lfsr_r[0] ? LFSR_MASK : '0);
    phase_nxt    = phase_r;
    held_nxt     = held_r;
    lfsr_nxt     = lfsr_r;
    if (in_fire) begin
      if (in_cmd == CMD_SYNC) begin
        phase_nxt = '0;
      end else begin
        phase_nxt = phase_sum[31:0];
        if (waveform_r == WAVE_SAMPLE && phase_sum[32]) begin
          lfsr_nxt = lfsr_step;
          held_nxt = $signed(lfsr_step[31:16]);
        end
      end
    end
  end

  // state and valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      held_r      <= '0;
      lfsr_r      <= LFSR_SEED;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      lfsr_r  <= lfsr_nxt;
      if (s1_ready) begin
        s1_valid_r <= adv_fire;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
      if (out_stage_ready) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  // stage 2 waveform shaping from the offset phase
  logic [TB-1:0]      sine_idx;
  logic [TB-2:0]      sine_dist;
  logic [14:0]        sine_mag;
  logic signed [17:0] tri_hi;
  logic signed [17:0] saw_dn;
  logic signed [15:0] v_nxt;
  always_comb begin
    sine_idx  = s1_p_r[31 -: TB];
    sine_dist = sine_idx[TB-2] ? ((TB-1)'(QSIZE) - {1'b0, sine_idx[TB-3:0]})
                               : {1'b0, sine_idx[TB-3:0]};
    sine_mag  = sine_q[sine_dist];
    tri_hi    = 18'sd98304 - $signed({1'b0, s1_p_r[31:15]});
    saw_dn    = 18'sd32768 - $signed({2'b00, s1_p_r[31:16]});
    case (s1_wave_r)
      WAVE_SINE: begin
        v_nxt = sine_idx[TB-1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
      end
      WAVE_TRIANGLE: begin
        if (!s1_p_r[31]) begin
          v_nxt = $signed({~s1_p_r[30], s1_p_r[29:15]});
        end else if (tri_hi > 18'sd32767) begin
          v_nxt = 16'sh7FFF;
        end else begin
          v_nxt = tri_hi[15:0];
        end
      end
      WAVE_SAW_UP:   v_nxt = $signed({~s1_p_r[31], s1_p_r[30:16]});
      WAVE_SAW_DOWN: v_nxt = (saw_dn > 18'sd32767) ? 16'sh7FFF : saw_dn[15:0];
      WAVE_SQUARE:   v_nxt = s1_p_r[31] ? 16'sh8000 : 16'sh7FFF;
      WAVE_SAMPLE:   v_nxt = s1_held_r;
      default:       v_nxt = '0;
    endcase
  end

  // stage 4 shift, saturation and unipolar offset
  logic signed [17:0] scaled;
  logic signed [15:0] bip_nxt;
  logic signed [17:0] uni_sum;
  logic [16:0]        uni_half;
  logic [14:0]        uni_nxt;
  always_comb begin
    scaled = s3_prod_r[32:15];
    if (scaled > 18'sd32767) begin
      bip_nxt = 16'sh7FFF;
    end else if (scaled < -18'sd32768) begin
      bip_nxt = 16'sh8000;
    end else begin
      bip_nxt = scaled[15:0];
    end
    uni_sum  = 18'(bip_nxt) + $signed({2'b00, depth_r});
    uni_half = uni_sum[17] ? '0 : uni_sum[17:1];
    uni_nxt  = (uni_half > 17'd32767) ? 15'h7FFF : uni_half[14:0];
  end

  // pipeline payload registers
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_p_r    <= phase_r + phase_ofs_r;
      s1_wave_r <= waveform_r;
      s1_held_r <= held_nxt;
    end
    if (s2_ready) begin
      s2_v_r <= v_nxt;
    end
    if (s3_ready) begin
      s3_prod_r <= s2_v_r * $signed({1'b0, depth_r});
    end
    if (out_stage_ready) begin
      out_bipolar_r  <= bip_nxt;
      out_unipolar_r <= uni_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_bipolar  = out_bipolar_r;
  assign out_unipolar = out_unipolar_r;

`ifndef SYNTHESIS
  // a sync transfer leaves the phase at zero
  a_sync_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_SYNC |=> phase_r == '0)
    else $error("phase not cleared after sync");

  // the noise lfsr never locks up at zero
  a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0)
    else $error("noise lfsr reached zero");

  // the hold value only moves on a sample-and-hold advance
  a_held_steady: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv_fire && waveform_r == WAVE_SAMPLE) |=> $stable(held_r))
    else $error("hold value changed without a refresh");

  // an empty first stage always takes a transfer
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with a free first stage");
`endif

endmodule
